/* design/flti_pkg.sv */
// Package for the in-order binary tree index iterator.
// Holds widths, the move codes and the decode-stage record; no dependencies.
package flti_pkg;

   localparam int INDEX_BITS = 64;                      // arithmetic width, 8 to 64
   localparam int FIELD_BITS = 64;                      // width of the index fields
   localparam int SHIFT_BITS = $clog2(INDEX_BITS);      // holds a trailing-ones count

   typedef logic [INDEX_BITS-1:0] idx_type;
   typedef logic [FIELD_BITS-1:0] field_type;
   typedef logic [SHIFT_BITS-1:0] depth_type;

   localparam idx_type IDX_ZERO = idx_type'(0);
   localparam idx_type IDX_ONE  = idx_type'(1);
   localparam idx_type IDX_TWO  = idx_type'(2);

   typedef enum logic [3:0] {
      OP_SEEK        = 4'd0,
      OP_NEXT        = 4'd1,
      OP_PREV        = 4'd2,
      OP_PARENT      = 4'd3,
      OP_LEFT_CHILD  = 4'd4,
      OP_RIGHT_CHILD = 4'd5,
      OP_LEFT_SPAN   = 4'd6,
      OP_RIGHT_SPAN  = 4'd7,
      OP_SIBLING     = 4'd8,
      OP_QUERY       = 4'd9
   } op_type;

   // Contents of the decode stage register.
   typedef struct packed {
      logic      valid;
      op_type    op;
      idx_type   idx;
      idx_type   factor;    // 2^(depth+1), zero when that wraps
      depth_type depth;     // trailing ones of idx
      logic      all_ones;  // idx has no zero bit
   } seek_dec_type;

endpackage

/* design/flti_if.sv */
// Valid/ready channel interfaces for the iterator's request and response.
// Depends on flti_pkg for the field types.
interface flti_req_if;
   logic               valid;
   logic               ready;
   logic [3:0]         op;
   flti_pkg::field_type seek_index;

   modport source (output valid, output op, output seek_index, input ready);
   modport sink   (input valid, input op, input seek_index, output ready);
endinterface

interface flti_rsp_if;
   logic               valid;
   logic               ready;
   flti_pkg::field_type node_index;
   flti_pkg::field_type level_offset;
   logic               is_left;

   modport source (output valid, output node_index, output level_offset, output is_left,
                   input ready);
   modport sink   (input valid, input node_index, input level_offset, input is_left,
                   output ready);
endinterface

/* design/flti_seek_dec.sv */
// Decode stage: finds the trailing-ones depth and step factor of an index.
// Depends on flti_pkg; registers its result when the pipeline advances.
module flti_seek_dec (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  flti_pkg::op_type      in_op,
   input  flti_pkg::idx_type     in_idx,
   output flti_pkg::seek_dec_type dec
);

   flti_pkg::seek_dec_type dec_ff;
   flti_pkg::seek_dec_type dec_in;
   flti_pkg::idx_type      low_zero;

   // Binary position of a one-hot word.
   function automatic flti_pkg::depth_type encode(input flti_pkg::idx_type onehot);
      flti_pkg::depth_type pos;
      pos = '0;
      for (int b = 0; b < flti_pkg::SHIFT_BITS; b++) begin
         for (int i = 0; i < flti_pkg::INDEX_BITS; i++) begin
            if (((i >> b) & 1) != 0) begin
               pos[b] = pos[b] | onehot[i];
            end
         end
      end
      return pos;
   endfunction

   // The lowest zero bit marks the end of the run of trailing ones.
   assign low_zero = ~in_idx & (in_idx + flti_pkg::IDX_ONE);

   always_comb begin
      dec_in.valid    = in_valid;
      dec_in.op       = in_op;
      dec_in.idx      = in_idx;
      dec_in.factor   = low_zero << 1;
      dec_in.depth    = encode(low_zero);
      dec_in.all_ones = (low_zero == flti_pkg::IDX_ZERO);
   end

   // Only the valid bit is reset; the payload simply follows the pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         dec_ff.valid <= 1'b0;
      end else if (advance) begin
         dec_ff.valid <= dec_in.valid;
      end
      if (advance) begin
         dec_ff.op       <= dec_in.op;
         dec_ff.idx      <= dec_in.idx;
         dec_ff.factor   <= dec_in.factor;
         dec_ff.depth    <= dec_in.depth;
         dec_ff.all_ones <= dec_in.all_ones;
      end
   end

   assign dec = dec_ff;

endmodule

/* design/flti_core.sv */
// Top level of the in-order binary tree index iterator.
// Depends on flti_pkg, flti_if (channels) and flti_seek_dec (decode stage).
//
// Usage: the request channel carries one move per item (op, and seek_index for
// a seek). Every request item yields exactly one response item with the node
// index, its offset within its tree level and the is_left flag, in order.
// The iterator state (index, offset, step factor) lives in this block and each
// move acts on the state left by the previous one.
//
// The pipeline has three register stages: the request register, the decode
// register holding the trailing-ones depth of the seek index, and the state
// together with the response register. A request item that is taken passes through
// these registers in order before its response is presented, and one item is taken in
// every cycle while the receiver takes responses. The state loop (adders, shifts
// and a final select) sets that rate.
//
// Reset is synchronous and clears the pipeline valids and sets the state to
// index 0, offset 0, factor 2, as after a seek to index 0.
// When the receiver stalls, the response register holds its item and the
// whole pipeline freezes; request ready falls in the same cycle.
module flat_tree_iterator_core (
   input logic             clock,
   input logic             reset,
   flti_req_if.sink        req_ch,
   flti_rsp_if.source      rsp_ch
);

   // Pipeline moves when the response register is empty or being taken.
   logic advance;

   // Request stage.
   logic              in_valid_ff;
   flti_pkg::op_type  in_op_ff;
   flti_pkg::idx_type in_idx_ff;

   // Decode stage.
   flti_pkg::seek_dec_type dec;

   // Iterator state.
   flti_pkg::idx_type index_ff,  index_in;
   flti_pkg::idx_type offset_ff, offset_in;
   flti_pkg::idx_type factor_ff, factor_in;

   // Response stage.
   logic              rsp_valid_ff, rsp_valid_in;
   flti_pkg::idx_type rsp_index_ff;
   flti_pkg::idx_type rsp_offset_ff;

   // Helpers for the move logic.
   flti_pkg::idx_type half;
   flti_pkg::idx_type child_factor;
   flti_pkg::idx_type span_index;
   flti_pkg::idx_type seek_offset;
   logic              do_move;

   assign advance     = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = advance;
   assign do_move     = advance && dec.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_op_ff  <= flti_pkg::op_type'(req_ch.op);
         in_idx_ff <= req_ch.seek_index[flti_pkg::INDEX_BITS-1:0];
      end
   end

   flti_seek_dec u_seek_dec (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (in_valid_ff),
      .in_op    (in_op_ff),
      .in_idx   (in_idx_ff),
      .dec      (dec)
   );

   // A seek takes the offset as the index shifted past its trailing ones and
   // the following zero. An index of all ones lands at offset zero.
   assign seek_offset  = dec.all_ones ? flti_pkg::IDX_ZERO : ((dec.idx >> 1) >> dec.depth);
   assign half         = factor_ff >> 1;
   assign child_factor = factor_ff >> 1;

   // Spans reach the leftmost or rightmost leaf below the current node.
   always_comb begin
      if (dec.op == flti_pkg::OP_RIGHT_SPAN) begin
         span_index = index_ff + half - flti_pkg::IDX_ONE;
      end else begin
         span_index = index_ff - half + flti_pkg::IDX_ONE;
      end
   end

   // One move applied to the current state.
   always_comb begin
      index_in  = index_ff;
      offset_in = offset_ff;
      factor_in = factor_ff;
      unique case (dec.op)
         flti_pkg::OP_SEEK: begin
            index_in  = dec.idx;
            offset_in = seek_offset;
            factor_in = dec.factor;
         end
         flti_pkg::OP_NEXT: begin
            index_in  = index_ff + factor_ff;
            offset_in = offset_ff + flti_pkg::IDX_ONE;
         end
         flti_pkg::OP_PREV: begin
            // Holds at the left edge of the level.
            if (offset_ff != flti_pkg::IDX_ZERO) begin
               index_in  = index_ff - factor_ff;
               offset_in = offset_ff - flti_pkg::IDX_ONE;
            end
         end
         flti_pkg::OP_PARENT: begin
            // A right child's parent lies below it, a left child's above.
            if (offset_ff[0]) begin
               index_in = index_ff - half;
            end else begin
               index_in = index_ff + half;
            end
            offset_in = offset_ff >> 1;
            factor_in = factor_ff << 1;
         end
         flti_pkg::OP_LEFT_CHILD: begin
            // Leaves have no children; the move holds there.
            if (factor_ff != flti_pkg::IDX_TWO) begin
               factor_in = child_factor;
               index_in  = index_ff - (child_factor >> 1);
               offset_in = offset_ff << 1;
            end
         end
         flti_pkg::OP_RIGHT_CHILD: begin
            if (factor_ff != flti_pkg::IDX_TWO) begin
               factor_in = child_factor;
               index_in  = index_ff + (child_factor >> 1);
               offset_in = (offset_ff << 1) | flti_pkg::IDX_ONE;
            end
         end
         flti_pkg::OP_LEFT_SPAN, flti_pkg::OP_RIGHT_SPAN: begin
            index_in  = span_index;
            offset_in = span_index >> 1;
            factor_in = flti_pkg::IDX_TWO;
         end
         flti_pkg::OP_SIBLING: begin
            // An odd offset is never zero, so prev always moves here.
            if (!offset_ff[0]) begin
               index_in  = index_ff + factor_ff;
               offset_in = offset_ff + flti_pkg::IDX_ONE;
            end else begin
               index_in  = index_ff - factor_ff;
               offset_in = offset_ff - flti_pkg::IDX_ONE;
            end
         end
         default: begin
            // Query and the unused codes leave the state alone.
            index_in  = index_ff;
            offset_in = offset_ff;
            factor_in = factor_ff;
         end
      endcase
   end

   assign rsp_valid_in = advance ? dec.valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff     <= flti_pkg::IDX_ZERO;
         offset_ff    <= flti_pkg::IDX_ZERO;
         factor_ff    <= flti_pkg::IDX_TWO;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (do_move) begin
            index_ff  <= index_in;
            offset_ff <= offset_in;
            factor_ff <= factor_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_move) begin
         rsp_index_ff  <= index_in;
         rsp_offset_ff <= offset_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.node_index   = flti_pkg::field_type'(rsp_index_ff);
   assign rsp_ch.level_offset = flti_pkg::field_type'(rsp_offset_ff);
   assign rsp_ch.is_left      = !rsp_offset_ff[0];

   // The step factor is always a single power of two, or zero once it wraps.
   assert property (@(posedge clock) disable iff (reset) $onehot0(factor_ff))
      else $error("step factor is not a power of two or zero");

   // A held response must stop new requests in the same cycle.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("request taken while the response is stalled");

   // A response appears only for an item that sat in the decode stage.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(dec.valid))
      else $error("response raised without a decoded item");

   // A query moves nothing.
   assert property (@(posedge clock) disable iff (reset)
      (do_move && dec.op == flti_pkg::OP_QUERY) |=>
         ($stable(index_ff) && $stable(offset_ff) && $stable(factor_ff)))
      else $error("query changed the iterator state");

endmodule
